// ===== rtl/core/dfs_pkg.sv =====
package dfs_pkg;

  localparam int VERTEX_W = 6;
  localparam int COUNT_W  = 7;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  typedef logic [VERTEX_W-1:0] vertex_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic add_slot;
    logic add_link;
    logic trav_init;
    logic root_next;
    logic root_push;
    logic pop;
    logic visit;
    logic edge_start;
    logic edge_step;
    logic flush;
  } dfs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_trav;
    logic add_ok;
    logic root_done;
    logic root_visited;
    logic stack_empty;
    logic emit_block;
    logic head_ok;
    logic next_ok;
    logic flush_block;
  } dfs_sts_t;

endpackage

// ===== rtl/core/dfs_req_if.sv =====
interface dfs_req_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  dfs_pkg::vertex_t  edge_from;
  dfs_pkg::vertex_t  edge_to;

  modport source (output valid, output req_type, output edge_from, output edge_to,
                  input ready);
  modport sink (input valid, input req_type, input edge_from, input edge_to,
                output ready);
endinterface

// ===== rtl/core/dfs_res_if.sv =====
interface dfs_res_if;
  logic              valid;
  logic              ready;
  dfs_pkg::vertex_t  vertex;
  logic              last;
  logic              overflow;

  modport source (output valid, output vertex, output last, output overflow,
                  input ready);
  modport sink (input valid, input vertex, input last, input overflow,
                output ready);
endinterface

// ===== rtl/core/dfs_ctrl.sv =====
module dfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dfs_pkg::dfs_sts_t sts,
  output dfs_pkg::dfs_cmd_t cmd
);
  import dfs_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_ADD_SLOT = 10'b00_0000_0010,
    S_ADD_LINK = 10'b00_0000_0100,
    S_TINIT    = 10'b00_0000_1000,
    S_ROOT     = 10'b00_0001_0000,
    S_POP      = 10'b00_0010_0000,
    S_VISIT    = 10'b00_0100_0000,
    S_HEAD     = 10'b00_1000_0000,
    S_EDGE     = 10'b01_0000_0000,
    S_FLUSH    = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.req_trav) begin
            state_next = S_TINIT;
          end else if (sts.add_ok) begin
            state_next = S_ADD_SLOT;
          end
        end
      end
      S_ADD_SLOT: begin
        cmd.add_slot = 1'b1;
        state_next   = S_ADD_LINK;
      end
      S_ADD_LINK: begin
        cmd.add_link = 1'b1;
        state_next   = S_IDLE;
      end
      S_TINIT: begin
        cmd.trav_init = 1'b1;
        state_next    = S_ROOT;
      end
      S_ROOT: begin
        if (sts.root_done) begin
          state_next = S_FLUSH;
        end else if (sts.root_visited) begin
          cmd.root_next = 1'b1;
        end else begin
          cmd.root_push = 1'b1;
          state_next    = S_POP;
        end
      end
      S_POP: begin
        if (sts.stack_empty) begin
          // walk of this root is finished
          cmd.root_next = 1'b1;
          state_next    = S_ROOT;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_VISIT;
        end
      end
      S_VISIT: begin
        if (!sts.emit_block) begin
          cmd.visit  = 1'b1;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.edge_start = 1'b1;
        state_next     = sts.head_ok ? S_EDGE : S_POP;
      end
      S_EDGE: begin
        cmd.edge_step = 1'b1;
        if (!sts.next_ok) begin
          state_next = S_POP;
        end
      end
      S_FLUSH: begin
        if (!sts.flush_block) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/dfs_dpath.sv =====
module dfs_dpath #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int STACK_DEPTH  = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  dfs_pkg::count_t   cfg_data,
  input  logic              in_type,
  input  dfs_pkg::vertex_t  in_from,
  input  dfs_pkg::vertex_t  in_to,
  input  logic              out_ready,
  output logic              out_valid,
  output dfs_pkg::vertex_t  out_vertex,
  output logic              out_last,
  output logic              out_overflow,
  input  dfs_pkg::dfs_cmd_t cmd,
  output dfs_pkg::dfs_sts_t sts
);
  import dfs_pkg::*;

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int UW  = $clog2(MAX_EDGES + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int LW  = $clog2(STACK_DEPTH + 1);
  localparam count_t NMAX = COUNT_W'(MAX_VERTICES);

  // memories
  vertex_t          edge_target [MAX_EDGES];
  logic [EW:0]      edge_next   [MAX_EDGES];   // {valid, index}
  logic [EW-1:0]    list_head   [MAX_VERTICES];
  logic [EW-1:0]    list_tail   [MAX_VERTICES];
  vertex_t          walk_stack  [STACK_DEPTH];

  // registered read data
  vertex_t          target_rd;
  logic [EW:0]      next_rd;
  logic [EW-1:0]    head_rd;
  logic [EW-1:0]    tail_rd;
  vertex_t          stack_rd;

  count_t                  vertex_count;
  logic [MAX_VERTICES-1:0] head_valid;
  logic [MAX_VERTICES-1:0] visited;
  logic [UW-1:0]           edges_used;
  logic [LW-1:0]           stack_level;
  logic                    overflow_seen;
  count_t                  root;
  vertex_t                 from_q;
  vertex_t                 to_q;
  logic                    head_hit;

  logic                    pend_valid;
  vertex_t                 pend_vertex;
  logic                    pend_ovf;

  count_t           n_act;
  logic [EW-1:0]    slot;
  logic [LW-1:0]    lvl_dec;
  logic [VIW-1:0]   u_idx;
  logic [VIW-1:0]   t_idx;
  logic             u_new;
  logic             t_push;
  logic             stack_full;
  logic             out_free;
  logic             edge_rd_en;
  logic [EW-1:0]    edge_rd_addr;
  logic             next_we;
  logic [EW-1:0]    next_wa;
  logic [EW:0]      next_wd;
  logic             stack_we;
  vertex_t          stack_wd;

  assign n_act      = (vertex_count > NMAX) ? NMAX : vertex_count;
  assign slot       = edges_used[EW-1:0];
  assign lvl_dec    = stack_level - LW'(1);
  assign u_idx      = stack_rd[VIW-1:0];
  assign t_idx      = target_rd[VIW-1:0];
  assign u_new      = !visited[u_idx];
  assign stack_full = (stack_level == LW'(STACK_DEPTH));
  assign t_push     = ({1'b0, target_rd} < n_act) && !visited[t_idx];
  assign out_free   = !out_valid || out_ready;

  assign sts.req_trav     = in_type;
  assign sts.add_ok       = ({1'b0, in_from} < n_act) && ({1'b0, in_to} < n_act) &&
                            (edges_used != UW'(MAX_EDGES));
  assign sts.root_done    = (root == n_act);
  assign sts.root_visited = visited[root[VIW-1:0]];
  assign sts.stack_empty  = (stack_level == '0);
  assign sts.emit_block   = u_new && pend_valid && !out_free;
  assign sts.head_ok      = head_hit;
  assign sts.next_ok      = next_rd[EW];
  assign sts.flush_block  = pend_valid && !out_free;

  // edge and stack memory access muxing
  always_comb begin
    edge_rd_en   = cmd.edge_start || (cmd.edge_step && next_rd[EW]);
    edge_rd_addr = cmd.edge_start ? head_rd : next_rd[EW-1:0];
    next_we      = cmd.add_slot || (cmd.add_link && head_hit);
    next_wa      = cmd.add_slot ? slot : tail_rd;
    next_wd      = cmd.add_slot ? {1'b0, {EW{1'b0}}} : {1'b1, slot};
    stack_we     = cmd.root_push || (cmd.edge_step && t_push && !stack_full);
    stack_wd     = cmd.root_push ? root[VERTEX_W-1:0] : target_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.add_slot) begin
      edge_target[slot] <= to_q;
    end
    if (next_we) begin
      edge_next[next_wa] <= next_wd;
    end
    if (edge_rd_en) begin
      target_rd <= edge_target[edge_rd_addr];
      next_rd   <= edge_next[edge_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_link) begin
      list_tail[from_q[VIW-1:0]] <= slot;
      if (!head_hit) begin
        list_head[from_q[VIW-1:0]] <= slot;
      end
    end
    if (cmd.add_slot) begin
      tail_rd <= list_tail[from_q[VIW-1:0]];
    end
    if (cmd.visit) begin
      head_rd <= list_head[u_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      walk_stack[stack_level[SAW-1:0]] <= stack_wd;
    end
    if (cmd.pop) begin
      stack_rd <= walk_stack[lvl_dec[SAW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      from_q <= in_from;
      to_q   <= in_to;
    end
    if (cmd.add_slot) begin
      head_hit <= head_valid[from_q[VIW-1:0]];
    end else if (cmd.visit) begin
      head_hit <= head_valid[u_idx];
    end
    if (cmd.visit && u_new) begin
      pend_vertex <= stack_rd;
      pend_ovf    <= overflow_seen;
    end
    if (cmd.visit && u_new && pend_valid) begin
      out_vertex   <= pend_vertex;
      out_last     <= 1'b0;
      out_overflow <= pend_ovf;
    end else if (cmd.flush && pend_valid) begin
      out_vertex   <= pend_vertex;
      out_last     <= 1'b1;
      out_overflow <= overflow_seen;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= COUNT_RESET;
      head_valid    <= '0;
      visited       <= '0;
      edges_used    <= '0;
      stack_level   <= '0;
      overflow_seen <= 1'b0;
      root          <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_data;
      end
      if (cmd.add_link) begin
        head_valid[from_q[VIW-1:0]] <= 1'b1;
        edges_used                  <= edges_used + UW'(1);
      end
      if (cmd.trav_init) begin
        visited       <= '0;
        overflow_seen <= 1'b0;
        root          <= '0;
      end
      if (cmd.root_next) begin
        root <= root + COUNT_W'(1);
      end
      if (cmd.root_push) begin
        stack_level <= stack_level + LW'(1);
      end
      if (cmd.pop) begin
        stack_level <= lvl_dec;
      end
      if (cmd.visit && u_new) begin
        visited[u_idx] <= 1'b1;
        pend_valid     <= 1'b1;
      end
      if (cmd.edge_step && t_push) begin
        if (stack_full) begin
          overflow_seen <= 1'b1;
        end else begin
          stack_level <= stack_level + LW'(1);
        end
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if ((cmd.visit && u_new && pend_valid) || (cmd.flush && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/dfs_iterative_traversal.sv =====
// Edge add: accepted in S_IDLE, appended in S_ADD_SLOT, S_ADD_LINK; a rejected edge is dropped.
// Traversal: S_TINIT, S_ROOT per root, S_POP, S_VISIT and S_HEAD per popped vertex, S_EDGE
// per scanned edge, S_FLUSH; bar output stalls, stack and edge lists see one access per cycle.
// One item is in work at a time; the final result may wait in the output register.
// Reset (rst, synchronous): vertex_count = 64, all adjacency lists empty, no edges, stack
// empty. Edge and stack memories are not cleared and need no clearing pass.
module dfs_iterative_traversal #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int STACK_DEPTH  = 512
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  dfs_pkg::count_t cfg_data,
  dfs_req_if.sink         req,
  dfs_res_if.source       res
);
  import dfs_pkg::*;

  dfs_cmd_t cmd;
  dfs_sts_t sts;

  dfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dfs_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_type      (req.req_type),
    .in_from      (req.edge_from),
    .in_to        (req.edge_to),
    .out_ready    (res.ready),
    .out_valid    (res.valid),
    .out_vertex   (res.vertex),
    .out_last     (res.last),
    .out_overflow (res.overflow),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
